// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros used by the RTL of the response head parser.
// Define ASSERT_OFF to compile the checks out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);

`else

`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ===== design/hrp_pkg.sv =====
// ----------------------------------------------------------------------------
// hrp_pkg
// Types and constants of the HTTP response head parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hrp_pkg;

	localparam logic [7:0] CH_SP = 8'h20;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

	localparam int CODE_W = 10;
	localparam logic [CODE_W-1:0] CODE_MAX = 10'd999;

	typedef enum logic [2:0] {
		PH_VERSION = 3'd0,
		PH_CODE    = 3'd1,
		PH_REASON  = 3'd2,
		PH_HEADERS = 3'd3,
		PH_BODY    = 3'd4
	} phase_t;

	typedef enum logic [3:0] {
		CLS_VER_CHAR   = 4'd0,
		CLS_VER_END    = 4'd1,
		CLS_CODE_CHAR  = 4'd2,
		CLS_CODE_END   = 4'd3,
		CLS_REASON     = 4'd4,
		CLS_CR_SKIP    = 4'd5,
		CLS_STATUS_END = 4'd6,
		CLS_HDR_CHAR   = 4'd7,
		CLS_HDR_EOL    = 4'd8,
		CLS_HDRS_END   = 4'd9,
		CLS_BODY       = 4'd10
	} byte_class_t;

	typedef struct packed {
		phase_t              phase;
		logic [CODE_W-1:0]   code_acc;
		logic                code_err;
		logic                line_nonempty;
	} parse_state_t;

endpackage

// ===== design/hrp_step.sv =====
// ----------------------------------------------------------------------------
// hrp_step
// Classifies one byte against the current parser state and forms the state
// that follows it. Purely combinational.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hrp_step (
	input  hrp_pkg::parse_state_t state_cur,
	input  logic [7:0]            data,
	input  logic                  restart,
	output hrp_pkg::parse_state_t state_nxt,
	output hrp_pkg::byte_class_t  cls
);
	import hrp_pkg::*;

	parse_state_t st;
	phase_t       ph_nxt;
	logic         is_digit;
	logic [13:0]  acc_sum;
	logic [CODE_W-1:0] acc_next;

	// A restart clears everything before this byte is looked at.
	always_comb begin
		if (restart) begin
			st = '{phase: PH_VERSION, code_acc: '0, code_err: 1'b0, line_nonempty: 1'b0};
		end else begin
			st = state_cur;
		end
	end

	assign is_digit = (data >= CH_ZERO) && (data <= CH_NINE);
	assign acc_sum  = ({4'b0, st.code_acc} << 3) + ({4'b0, st.code_acc} << 1)
		+ {10'b0, data[3:0]};
	assign acc_next = (acc_sum > {4'b0, CODE_MAX}) ? CODE_MAX : acc_sum[CODE_W-1:0];

	// Next phase.
	always_comb begin
		ph_nxt = st.phase;
		unique case (st.phase)
			PH_VERSION: begin
				if (data == CH_SP) ph_nxt = PH_CODE;
			end
			PH_CODE: begin
				if (data == CH_SP) ph_nxt = PH_REASON;
			end
			PH_REASON: begin
				if (data == CH_LF) ph_nxt = PH_HEADERS;
			end
			PH_HEADERS: begin
				if (data == CH_LF && !st.line_nonempty) ph_nxt = PH_BODY;
			end
			default: ph_nxt = st.phase;
		endcase
	end

	// Class and data state.
	always_comb begin
		cls                     = CLS_BODY;
		state_nxt.phase         = ph_nxt;
		state_nxt.code_acc      = st.code_acc;
		state_nxt.code_err      = st.code_err;
		state_nxt.line_nonempty = st.line_nonempty;
		unique case (st.phase)
			PH_VERSION: begin
				if (data == CH_SP) begin
					cls                = CLS_VER_END;
					state_nxt.code_acc = '0;
					state_nxt.code_err = 1'b0;
				end else begin
					cls = CLS_VER_CHAR;
				end
			end
			PH_CODE: begin
				if (data == CH_SP) begin
					cls = CLS_CODE_END;
				end else begin
					cls = CLS_CODE_CHAR;
					if (is_digit) state_nxt.code_acc = acc_next;
					else          state_nxt.code_err = 1'b1;
				end
			end
			PH_REASON: begin
				if (data == CH_CR) begin
					cls = CLS_CR_SKIP;
				end else if (data == CH_LF) begin
					cls                     = CLS_STATUS_END;
					state_nxt.line_nonempty = 1'b0;
				end else begin
					cls = CLS_REASON;
				end
			end
			PH_HEADERS: begin
				if (data == CH_CR) begin
					cls = CLS_CR_SKIP;
				end else if (data == CH_LF) begin
					if (st.line_nonempty) begin
						cls                     = CLS_HDR_EOL;
						state_nxt.line_nonempty = 1'b0;
					end else begin
						cls = CLS_HDRS_END;
					end
				end else begin
					cls                     = CLS_HDR_CHAR;
					state_nxt.line_nonempty = 1'b1;
				end
			end
			default: cls = CLS_BODY;
		endcase
	end

endmodule

// ===== design/http_response_head_parser.sv =====
// ----------------------------------------------------------------------------
// http_response_head_parser
// Tags each byte of an HTTP response with its class and tracks the status code.
// ----------------------------------------------------------------------------
// One byte is taken per clock cycle while the result side does not stall. Each
// beat is captured in an input register, classified against the parser state
// by a single level of logic, and its result lands in an output register once
// that register is free or its result is taken. The input keeps accepting while
// a result waits, as long as that result is taken in the same cycle. A byte
// with restart set returns the parser to the version phase before the byte is
// classified.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module http_response_head_parser (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	output logic       byte_stall,
	input  logic [7:0] data_byte,
	input  logic       restart,
	output logic       result_valid,
	input  logic       result_stall,
	output logic [3:0] byte_class,
	output logic [7:0] byte_out,
	output logic [9:0] status_code,
	output logic       code_bad
);
	import hrp_pkg::*;

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         restart_s1;
	logic         advance;
	logic         result_valid_q;
	byte_class_t  cls_q;
	logic [7:0]   byte_q;
	parse_state_t state_q;
	parse_state_t state_nxt;
	byte_class_t  cls_nxt;

	assign advance    = valid_s1 && (!result_valid_q || !result_stall);
	assign byte_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			byte_s1    <= data_byte;
			restart_s1 <= restart;
		end
	end

	hrp_step u_step (
		.state_cur (state_q),
		.data      (byte_s1),
		.restart   (restart_s1),
		.state_nxt (state_nxt),
		.cls       (cls_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
			state_q        <= '{phase: PH_VERSION, code_acc: '0, code_err: 1'b0,
				line_nonempty: 1'b0};
		end else begin
			if (advance) begin
				result_valid_q <= 1'b1;
				state_q        <= state_nxt;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			cls_q  <= cls_nxt;
			byte_q <= byte_s1;
		end
	end

	// The shown result always belongs to the last byte folded into the state,
	// so the code fields come straight from the state register.
	assign result_valid = result_valid_q;
	assign byte_class   = cls_q;
	assign byte_out     = byte_q;
	assign status_code  = state_q.code_acc;
	assign code_bad     = state_q.code_err;

	`ASSERT_IMPLY(a_stall_needs_item, clk, arst_n, byte_stall, valid_s1,
		"stall without a held beat")
	`ASSERT_IMPLY(a_code_in_range, clk, arst_n, 1'b1, state_q.code_acc <= CODE_MAX,
		"code above 999")
	`ASSERT_IMPLY(a_hdrs_end_body, clk, arst_n, result_valid_q && cls_q == CLS_HDRS_END,
		state_q.phase == PH_BODY, "end of headers without body phase")
	`ASSERT_NEXT(a_state_holds, clk, arst_n, !advance, $stable(state_q),
		"state moved without a beat")
	`ASSERT_IMPLY(a_body_phase, clk, arst_n, result_valid_q && cls_q == CLS_BODY,
		state_q.phase != PH_VERSION && state_q.phase != PH_CODE &&
		state_q.phase != PH_REASON && state_q.phase != PH_HEADERS,
		"body byte outside body phase")

endmodule

// ===== sim/http_response_head_parser_tb.sv =====
// ----------------------------------------------------------------------------
// http_response_head_parser_tb
// Self-checking bench for the HTTP response head parser.
// ----------------------------------------------------------------------------
// A queue of response bytes is built up front. It starts with a short
// hand-written stream through every byte class, then holds random responses:
// version, code, reason, header lines and body, mixed with noise and restarts
// in the middle of a response. A clocked driver sends the bytes with random
// gaps, and a clocked monitor applies random stalls on the result side. Every
// accepted beat is run through a behavioral parser, and each result beat is
// compared field by field with the oldest tag that the parser produced.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module http_response_head_parser_tb;
	import hrp_pkg::*;

	typedef struct {
		logic [7:0] b;
		logic       rst;
		bit         drain;
	} stream_byte_t;

	typedef struct {
		byte_class_t       cls;
		logic [7:0]        b;
		logic [CODE_W-1:0] code;
		logic              bad;
	} byte_tag_t;

	logic              clk;
	logic              arst_n;
	logic              byte_valid;
	logic              byte_stall;
	logic [7:0]        data_byte;
	logic              restart;
	logic              result_valid;
	logic              result_stall;
	logic [3:0]        byte_class;
	logic [7:0]        byte_out;
	logic [9:0]        status_code;
	logic              code_bad;

	stream_byte_t      stream_q[$];
	byte_tag_t         tag_q[$];

	// Behavioral copy of the parser state.
	phase_t            m_phase;
	logic [CODE_W-1:0] m_code;
	logic              m_bad;
	logic              m_nonempty;

	logic              in_fire;
	logic              out_fire;
	int                tx_gap;
	int                tx_calm;
	int                rx_wait;
	int                rx_calm;
	int                errors;
	int                checked_n;
	int                gen_n;
	int                resp_n;
	int                restart_n;
	int                class_hits[11];
	stream_byte_t      cur;
	byte_tag_t         want;

	http_response_head_parser DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.data_byte    (data_byte),
		.restart      (restart),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.byte_class   (byte_class),
		.byte_out     (byte_out),
		.status_code  (status_code),
		.code_bad     (code_bad)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic byte_tag_t classify_byte(input logic [7:0] b, input logic rst);
		byte_tag_t t;
		int        v;
		if (rst) begin
			m_phase    = PH_VERSION;
			m_code     = '0;
			m_bad      = 1'b0;
			m_nonempty = 1'b0;
		end
		case (m_phase)
			PH_VERSION: begin
				if (b == CH_SP) begin
					t.cls   = CLS_VER_END;
					m_code  = '0;
					m_bad   = 1'b0;
					m_phase = PH_CODE;
				end else begin
					t.cls = CLS_VER_CHAR;
				end
			end
			PH_CODE: begin
				if (b == CH_SP) begin
					t.cls   = CLS_CODE_END;
					m_phase = PH_REASON;
				end else begin
					t.cls = CLS_CODE_CHAR;
					if (b >= CH_ZERO && b <= CH_NINE) begin
						v      = int'(m_code) * 10 + int'(b - CH_ZERO);
						m_code = (v > int'(CODE_MAX)) ? CODE_MAX : v[CODE_W-1:0];
					end else begin
						m_bad = 1'b1;
					end
				end
			end
			PH_REASON: begin
				if (b == CH_CR) begin
					t.cls = CLS_CR_SKIP;
				end else if (b == CH_LF) begin
					t.cls      = CLS_STATUS_END;
					m_nonempty = 1'b0;
					m_phase    = PH_HEADERS;
				end else begin
					t.cls = CLS_REASON;
				end
			end
			PH_HEADERS: begin
				if (b == CH_CR) begin
					t.cls = CLS_CR_SKIP;
				end else if (b == CH_LF) begin
					if (m_nonempty) begin
						t.cls      = CLS_HDR_EOL;
						m_nonempty = 1'b0;
					end else begin
						t.cls   = CLS_HDRS_END;
						m_phase = PH_BODY;
					end
				end else begin
					t.cls      = CLS_HDR_CHAR;
					m_nonempty = 1'b1;
				end
			end
			default: begin
				t.cls = CLS_BODY;
			end
		endcase
		t.b    = b;
		t.code = m_code;
		t.bad  = m_bad;
		return t;
	endfunction

	// Mostly random waits, with occasional runs of back-to-back beats.
	function automatic int draw_gap(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0) begin
			calm = int'($urandom_range(10, 50));
			return 0;
		end
		return int'($urandom_range(0, 17));
	endfunction

	function automatic logic [7:0] rand_byte_except(input logic [7:0] x, input logic [7:0] y);
		logic [7:0] v;
		do v = 8'($urandom_range(0, 255)); while (v == x || v == y);
		return v;
	endfunction

	task automatic push_byte(input logic [7:0] b, input logic rst = 1'b0,
			input bit drain = 1'b0);
		stream_byte_t s;
		s.b     = b;
		s.rst   = rst;
		s.drain = drain;
		stream_q.push_back(s);
		gen_n++;
		if (rst)
			restart_n++;
	endtask

	// A bare LF or CR LF, now and then with a stray CR in front.
	task automatic push_eol();
		if ($urandom_range(0, 7) == 0)
			push_byte(CH_CR, $urandom_range(0, 39) == 0);
		if ($urandom_range(0, 2) != 0)
			push_byte(CH_CR, $urandom_range(0, 39) == 0);
		push_byte(CH_LF, $urandom_range(0, 39) == 0);
	endtask

	task automatic gen_response(input bit drain);
		int         n;
		logic [7:0] v;
		resp_n++;
		if ($urandom_range(0, 9) == 0) begin
			// Noise: raw bytes with random restarts.
			n = int'($urandom_range(5, 20));
			push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), drain);
			repeat (n - 1)
				push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
			return;
		end
		push_byte(rand_byte_except(CH_SP, CH_SP), $urandom_range(0, 9) != 0, drain);
		repeat ($urandom_range(0, 7))
			push_byte(rand_byte_except(CH_SP, CH_SP), $urandom_range(0, 39) == 0);
		push_byte(CH_SP, $urandom_range(0, 39) == 0);
		// Four digits or more can drive the code into saturation.
		repeat ($urandom_range(0, 5)) begin
			if ($urandom_range(0, 7) == 0) begin
				do v = 8'($urandom_range(0, 255));
				while (v == CH_SP || (v >= CH_ZERO && v <= CH_NINE));
			end else begin
				v = CH_ZERO + 8'($urandom_range(0, 9));
			end
			push_byte(v, $urandom_range(0, 39) == 0);
		end
		push_byte(CH_SP, $urandom_range(0, 39) == 0);
		repeat ($urandom_range(0, 8))
			push_byte(rand_byte_except(CH_CR, CH_LF), $urandom_range(0, 39) == 0);
		push_eol();
		repeat ($urandom_range(0, 3)) begin
			repeat ($urandom_range(1, 6))
				push_byte(rand_byte_except(CH_CR, CH_LF), $urandom_range(0, 39) == 0);
			push_eol();
		end
		push_eol();
		repeat ($urandom_range(0, 12))
			push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 39) == 0);
	endtask

	task automatic report_mismatch(input string field, input logic [15:0] got,
			input logic [15:0] exp_val);
		errors++;
		$display("%0t ns: mismatch on result %0d, %s: got %0h, expected %0h",
			$time, checked_n, field, got, exp_val);
	endtask

	// Driver: a beat is held until accepted, then the drawn gap follows.
	always @(negedge clk) begin
		if (arst_n) begin
			if (byte_valid && !in_fire) begin
			end else if (tx_gap > 0) begin
				byte_valid <= 1'b0;
				tx_gap--;
			end else if (stream_q.size() > 0 && !(stream_q[0].drain && tag_q.size() > 0)) begin
				cur = stream_q.pop_front();
				data_byte  <= cur.b;
				restart    <= cur.rst;
				byte_valid <= 1'b1;
				tx_gap = draw_gap(tx_calm);
			end else begin
				byte_valid <= 1'b0;
			end
		end
	end

	// Result side: the stall count only runs down while a result waits.
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_fire)
				rx_wait = draw_gap(rx_calm);
			else if (result_valid && rx_wait > 0)
				rx_wait--;
			result_stall <= (rx_wait > 0);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			in_fire  <= byte_valid && !byte_stall;
			out_fire <= result_valid && !result_stall;
			if (byte_valid && !byte_stall)
				tag_q.push_back(classify_byte(data_byte, restart));
			if (result_valid && !result_stall) begin
				if (tag_q.size() == 0) begin
					report_mismatch("unexpected result, byte_out", 16'(byte_out), 16'h0);
				end else begin
					want = tag_q.pop_front();
					if (byte_class !== want.cls)
						report_mismatch("byte_class", 16'(byte_class), 16'(want.cls));
					if (byte_out !== want.b)
						report_mismatch("byte_out", 16'(byte_out), 16'(want.b));
					if (status_code !== want.code)
						report_mismatch("status_code", 16'(status_code), 16'(want.code));
					if (code_bad !== want.bad)
						report_mismatch("code_bad", 16'(code_bad), 16'(want.bad));
					if (want.cls <= CLS_BODY)
						class_hits[want.cls]++;
				end
				checked_n++;
			end
		end else begin
			in_fire  <= 1'b0;
			out_fire <= 1'b0;
		end
	end

	initial begin
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		int seen;
		clk          = 1'b0;
		arst_n       = 1'b0;
		byte_valid   = 1'b0;
		data_byte    = '0;
		restart      = 1'b0;
		result_stall = 1'b0;
		in_fire      = 1'b0;
		out_fire     = 1'b0;
		tx_gap       = 0;
		tx_calm      = 0;
		rx_wait      = 0;
		rx_calm      = 0;
		errors       = 0;
		checked_n    = 0;
		gen_n        = 0;
		resp_n       = 0;
		restart_n    = 0;
		m_phase      = PH_VERSION;
		m_code       = '0;
		m_bad        = 1'b0;
		m_nonempty   = 1'b0;
		foreach (class_hits[i])
			class_hits[i] = 0;

		// Hand-written stream: extreme bytes, saturation at four nines, a
		// non-digit in the code, an empty header section, restart in body,
		// an empty code, and restart as the very first thing of a response.
		push_byte(8'h00, 1'b1);
		push_byte(8'hFF);
		push_byte(CH_SP);
		push_byte(CH_NINE);
		push_byte(CH_NINE);
		push_byte(CH_NINE);
		push_byte(CH_NINE);
		push_byte("x");
		push_byte(CH_SP);
		push_byte("O");
		push_byte(CH_CR);
		push_byte(CH_LF);
		push_byte("A");
		push_byte(CH_CR);
		push_byte(CH_LF);
		push_byte(CH_LF);
		push_byte(8'hFF);
		push_byte(CH_SP);
		push_byte(CH_SP, 1'b1);
		push_byte(CH_SP);
		push_byte(CH_LF);
		push_byte(CH_CR);
		push_byte(CH_LF);
		push_byte("5", 1'b1);

		gen_response(1'b1);
		while (gen_n < 824)
			gen_response($urandom_range(0, 11) == 0);

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (stream_q.size() > 0 || byte_valid || tag_q.size() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		seen = 0;
		foreach (class_hits[i])
			if (class_hits[i] > 0)
				seen++;
		$display("covered %0d bytes in %0d responses with %0d restarts, %0d results checked",
			gen_n, resp_n, restart_n, checked_n);
		$display("byte classes seen: %0d of 11, mismatches: %0d", seen, errors);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
